// ===== src/bfrms_pkg.sv =====
// bfrms_pkg: shared types, constants and fp32 multiply helpers for the
// bf16 rmsnorm scale block; no dependencies
`default_nettype none
package bfrms_pkg;

  localparam logic [31:0] EXP_FIELD = 32'h7F80_0000;
  localparam int unsigned BF16_SHIFT = 16;
  localparam logic [15:0] BF16_CANON_NAN = 16'h7FC0;
  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

  // operand classification and unpacked product data
  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic signed [10:0] exp;   // biased exponent sum of product, a single bias of 127 kept
    logic [47:0] mant;         // raw 24x24 product
  } mul_part_t;

  // split an fp32 word into its significand with hidden bit
  function automatic logic [23:0] f32_sig(input logic [31:0] a);
    f32_sig = {(a[30:23] != 8'd0), a[22:0]};
  endfunction

  // effective biased exponent, subnormals use 1
  function automatic logic [8:0] f32_exp(input logic [31:0] a);
    f32_exp = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
  endfunction

  // leading zero count of a 48-bit product
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    lzc48 = n;
  endfunction

  // normalize, round to nearest even and pack a product into fp32
  function automatic logic [31:0] f32_round(input mul_part_t p);
    logic [5:0]         lz;
    logic signed [11:0] e;
    logic [47:0]        m;
    logic [7:0]         rsh;
    logic [48:0]        sh;
    logic               sticky;
    logic [23:0]        sig;
    logic               rnd;
    logic [24:0]        sum;
    logic [7:0]         ef;
    if (p.is_nan) begin
      f32_round = F32_QNAN;
    end else if (p.is_inf) begin
      f32_round = {p.sign, 8'hFF, 23'd0};
    end else if (p.is_zero || p.mant == 48'd0) begin
      f32_round = {p.sign, 31'd0};
    end else begin
      lz = lzc48(p.mant);
      // value = mant * 2^(exp-bias-46); normalized top at bit 47 -> exp+1-lz
      e = 12'(p.exp) + 12'sd1 - 12'(lz);
      m = p.mant << lz;
      sticky = 1'b0;
      if (e < 12'sd1) begin
        rsh = (e < -12'sd48) ? 8'd50 : 8'(12'sd1 - e);
        sh = {m, 1'b0} >> rsh;
        for (int i = 0; i < 48; i++) begin
          if (i < rsh && m[i[5:0]]) sticky = 1'b1;
        end
        m = sh[48:1];
        e = 12'sd0;
      end
      sig = m[47:24];
      rnd = m[23];
      sticky = sticky | (m[22:0] != 23'd0);
      sum = {1'b0, sig} + 25'(rnd & (sticky | sig[0]));
      if (sum[24]) begin
        sum = sum >> 1;
        e = e + 12'sd1;
      end else if (e == 12'sd0 && sum[23]) begin
        e = 12'sd1;
      end
      if (e >= 12'sd255) begin
        f32_round = {p.sign, 8'hFF, 23'd0};
      end else begin
        ef = e[7:0];
        f32_round = {p.sign, ef, sum[22:0]};
      end
    end
  endfunction

  // multiply stage: classify and form the raw product
  function automatic mul_part_t f32_mul(input logic [31:0] a, input logic [31:0] b);
    mul_part_t r;
    logic a_nan, b_nan, a_inf, b_inf, a_z, b_z;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_z = (a[30:0] == 31'd0);
    b_z = (b[30:0] == 31'd0);
    r.sign = a[31] ^ b[31];
    r.is_nan = a_nan || b_nan || (a_inf && b_z) || (b_inf && a_z);
    r.is_inf = a_inf || b_inf;
    r.is_zero = a_z || b_z;
    r.exp = 11'($signed({2'b0, f32_exp(a)}) + $signed({2'b0, f32_exp(b)}) - 11'sd127);
    r.mant = f32_sig(a) * f32_sig(b);
    f32_mul = r;
  endfunction

  // fp32 to bf16 with round to nearest even and canonical nan
  function automatic logic [15:0] bf16_encode(input logic [31:0] bits);
    logic [31:0] s;
    if ((bits & EXP_FIELD) == EXP_FIELD && bits[22:0] != 23'd0) begin
      bf16_encode = BF16_CANON_NAN;
    end else begin
      s = bits + 32'h7FFF + {31'd0, bits[BF16_SHIFT]};
      bf16_encode = s[31:16];
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/bf16_rmsnorm_scale_store_top.sv =====
// bf16 rmsnorm normalize and scale: x * inverse (fp32 rne) * scale (fp32 rne)
// strobe follows start through the registered pipeline, one item per cycle, busy never high
// the receiver cannot stall; sync active-high reset clears the valid pipe
// pipeline: multiply, round, multiply, round, bf16 encode
// depends on bfrms_pkg
`default_nettype none
module bf16_rmsnorm_scale_store_top
  import bfrms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] x_code,
  input  wire logic [15:0] scale_code,
  input  wire logic [31:0] inverse_bits,
  output logic             strobe,
  output logic [15:0]      out_code
);

  logic [4:0]  vld;
  mul_part_t   p1;
  logic [15:0] sc1, sc2;
  logic [31:0] n2;
  mul_part_t   p3;
  logic [31:0] r4;
  logic [15:0] oc;

  assign busy = 1'b0;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[3:0], start};
  end

  // datapath stages
  always_ff @(posedge clk) begin
    p1  <= f32_mul({x_code, 16'd0}, inverse_bits);
    sc1 <= scale_code;
    n2  <= f32_round(p1);
    sc2 <= sc1;
    p3  <= f32_mul(n2, {sc2, 16'd0});
    r4  <= f32_round(p3);
    oc  <= bf16_encode(r4);
  end

  assign strobe   = vld[4];
  assign out_code = oc;

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start |-> ##5 strobe) else $error("lost item");
  a_nan: assert property (@(posedge clk) disable iff (rst)
    strobe && out_code[14:7] == 8'hFF && out_code[6:0] != 7'd0 |-> out_code == BF16_CANON_NAN)
    else $error("noncanonical nan");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_bf16_rmsnorm_scale_store_top.sv =====
// testbench for bf16_rmsnorm_scale_store_top: directed and random items,
// each result checked against an in-bench fp32/bf16 rounding model
// depends on bfrms_pkg and the block's rtl
`default_nettype none
module tb_bf16_rmsnorm_scale_store_top;
  import bfrms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // expected-code store and the arithmetic that fills it
  class rms_scoreboard;
    logic [15:0] pending_codes[$];
    int mismatches;
    int failures;

    // fp32 product with round to nearest even, subnormals kept
    function automatic logic [31:0] mul_f32_rne(logic [31:0] a, logic [31:0] b);
      logic s;
      logic [23:0] ma, mb;
      int ea, eb, e_lsb, n, be, sh;
      logic [63:0] p, q, rem_mask;
      logic guard, sticky;
      logic [7:0] ef;
      s = a[31] ^ b[31];
      if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
        return F32_QNAN;
      if ((a[30:23] == 8'hFF && b[30:0] == 0) || (b[30:23] == 8'hFF && a[30:0] == 0))
        return F32_QNAN;
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {s, 8'hFF, 23'd0};
      if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
      ma = {a[30:23] != 0, a[22:0]};
      mb = {b[30:23] != 0, b[22:0]};
      ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
      eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
      p = {40'd0, ma} * {40'd0, mb};
      e_lsb = ea + eb - 300;
      n = 0;
      for (int i = 0; i < 48; i++) if (p[i]) n = i;
      be = n + e_lsb + 127;
      if (be < 1) be = 1;
      sh = be - 150 - e_lsb;
      guard = 1'b0;
      sticky = 1'b0;
      if (sh <= 0) begin
        q = p << (-sh);
      end else if (sh > 60) begin
        q = 0;
        sticky = 1'b1;
      end else begin
        q = p >> sh;
        guard = p[sh-1];
        rem_mask = (64'd1 << (sh - 1)) - 1;
        sticky = (p & rem_mask) != 0;
      end
      if (guard && (sticky || q[0])) q = q + 1;
      if (q[24]) begin
        q = q >> 1;
        be = be + 1;
      end
      if (be >= 255) return {s, 8'hFF, 23'd0};
      ef = q[23] ? 8'(be) : 8'd0;
      return {s, ef, q[22:0]};
    endfunction

    // fp32 to bf16, nearest even, any nan to the canonical one
    function automatic logic [15:0] to_bf16(logic [31:0] f);
      logic [16:0] up;
      if (f[30:23] == 8'hFF && f[22:0] != 0) return BF16_CANON_NAN;
      up = {1'b0, f[31:16]};
      if (f[15] && (f[14:0] != 0 || f[16])) up = up + 17'd1;
      return up[15:0];
    endfunction

    function void note_item(logic [15:0] x, logic [15:0] sc, logic [31:0] inv);
      logic [31:0] normed;
      normed = mul_f32_rne({x, 16'd0}, inv);
      pending_codes.push_back(to_bf16(mul_f32_rne(normed, {sc, 16'd0})));
    endfunction

    function void check_code(logic [15:0] got);
      logic [15:0] want;
      if (pending_codes.size() == 0) begin
        failures++;
        if (mismatches++ < 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_codes.pop_front();
      if (got !== want) begin
        failures++;
        if (mismatches++ < 10) $display("out_code mismatch: expected %h got %h", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [15:0] x_code = '0;
  logic [15:0] scale_code = '0;
  logic [31:0] inverse_bits = '0;
  wire logic busy;
  wire logic strobe;
  wire logic [15:0] out_code;
  rms_scoreboard board = new();
  int cycles = 0;
  localparam int CYCLE_LIMIT = 40000;

  bf16_rmsnorm_scale_store_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_code(x_code), .scale_code(scale_code), .inverse_bits(inverse_bits),
    .strobe(strobe), .out_code(out_code)
  );

  always #1 clk = ~clk;

  // accepted items and results, sampled at the edge
  always @(posedge clk) begin
    if (!rst && start && !busy) board.note_item(x_code, scale_code, inverse_bits);
    if (!rst && strobe) board.check_code(out_code);
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // present one item and hold it until accepted
  task automatic send_item(logic [15:0] x, logic [15:0] sc, logic [31:0] inv);
    start <= 1'b1;
    x_code <= x;
    scale_code <= sc;
    inverse_bits <= inv;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // bf16 code from a class of interesting values
  function automatic logic [15:0] pick_code();
    logic [15:0] c;
    c = 16'($urandom);
    case ($urandom_range(0, 9))
      0: c[14:0] = 15'h0000;
      1: c[14:0] = 15'h7F80;
      2: c[14:7] = 8'hFF;
      3: c[14:7] = 8'h00;
      4: c[14:7] = 8'($urandom_range(100, 154));
      5: c[14:7] = 8'($urandom_range(200, 254));
      default: c[14:7] = 8'($urandom_range(110, 144));
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pick_inverse();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:0] = 31'd0;
      1: v[30:23] = 8'hFF;
      2: v[30:23] = 8'h00;
      3: v[30:23] = 8'($urandom_range(1, 40));
      4: v[30:23] = 8'($urandom_range(215, 254));
      default: v[30:23] = 8'($urandom_range(115, 140));
    endcase
    return v;
  endfunction

  initial begin
    logic [15:0] dx[20];
    logic [15:0] ds[20];
    logic [31:0] di[20];
    dx = '{16'h0000, 16'h8000, 16'h7F80, 16'h0000, 16'h7FC1, 16'h3F80, 16'h7F7F, 16'h0001,
           16'h8001, 16'h007F, 16'h3F81, 16'h3F80, 16'hFF80, 16'hFFFF, 16'h4000, 16'h0080,
           16'h3FC0, 16'hBF80, 16'h7F7F, 16'hC000};
    ds = '{16'h3F80, 16'h3F80, 16'h3F80, 16'h7F80, 16'h3F80, 16'hFFC0, 16'h7F7F, 16'h3F80,
           16'h3F80, 16'h0080, 16'h3F80, 16'h0001, 16'h0000, 16'h3F80, 16'h4000, 16'h3F00,
           16'h3F80, 16'h8000, 16'h3F80, 16'h3F80};
    di = '{32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000,
           32'h3F80_0000, 32'h7F7F_FFFF, 32'h3F00_0000, 32'h3F80_0000, 32'h3F80_0000,
           32'h3F80_8000, 32'h0000_0001, 32'h3F80_0000, 32'hFFFF_FFFF, 32'h7F00_0000,
           32'h0080_0001, 32'h3F7F_FFFF, 32'h8000_0000, 32'h3F80_8001, 32'h0000_0001};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners
    foreach (dx[i]) send_item(dx[i], ds[i], di[i]);
    // hold off until everything has drained
    start <= 1'b0;
    while (board.pending_codes.size() != 0) @(posedge clk);
    // random items, idle bursts except near the end
    for (int k = 0; k < 500; k++) begin
      if (k < 420 && $urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 18));
      send_item(pick_code(), pick_code(), pick_inverse());
    end
    start <= 1'b0;
    while (board.pending_codes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
